// ===== rtl/fuzzy_subsequence_scorer_core_macros.svh =====
// Assertion macros for the fuzzy subsequence scorer
`ifndef FUZZY_SUBSEQUENCE_SCORER_CORE_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fss_pkg.sv =====
// Shared types and constants for the fuzzy subsequence scorer
package fss_pkg;

  localparam int SCORE_W = 9;
  localparam int CHAR_W  = 16;
  localparam int LEN_W   = 4;
  localparam int SLOTS   = 8;

  typedef logic [SCORE_W-1:0] fss_score_t;
  typedef logic [CHAR_W-1:0]  fss_char_t;
  typedef logic [LEN_W-1:0]   fss_len_t;
  typedef logic [SLOTS-1:0][CHAR_W-1:0] fss_needle_t;

  localparam fss_score_t HIT_BASE    = 9'd10;
  localparam fss_score_t RUN_STEP    = 9'd5;
  localparam fss_score_t START_BONUS = 9'd15;
  localparam fss_score_t SCORE_MAX   = 9'd275;
  localparam fss_score_t EMPTY_SCORE = 9'd1;
  localparam fss_len_t   PENALTY_CAP = 4'd10;
  localparam fss_len_t   RUN_MAX     = 4'd15;

  typedef enum logic [1:0] {
    CFG_NEEDLE_LOW    = 2'd0,
    CFG_NEEDLE_HIGH   = 2'd1,
    CFG_NEEDLE_LENGTH = 2'd2
  } fss_cfg_idx_t;

  typedef struct packed {
    logic empty;
    logic matched;
  } fss_flags_t;

endpackage

// ===== rtl/fss_match.sv =====
// Greedy needle match: per-haystack running state and per-word update
module fss_match #(
  parameter int NEEDLE_MAX = 8,
  parameter int POS_WIDTH  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  fss_pkg::fss_char_t      hay_char,
  input  logic                    char_present,
  input  logic                    last_char,
  input  fss_pkg::fss_needle_t    needle_chars,
  input  fss_pkg::fss_len_t       needle_length,
  output fss_pkg::fss_score_t     score_upd,
  output logic [POS_WIDTH-1:0]    first_upd,
  output logic [POS_WIDTH-1:0]    last_upd,
  output fss_pkg::fss_len_t       active_len,
  output fss_pkg::fss_flags_t     flags
);

  localparam int IDX_W = $clog2(NEEDLE_MAX + 1);
  localparam logic [POS_WIDTH-1:0] POS_LIMIT = {POS_WIDTH{1'b1}};

  logic [IDX_W-1:0]     idx_r, idx_nxt, idx_upd;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  fss_pkg::fss_score_t  score_r, score_nxt;
  fss_pkg::fss_len_t    run_r, run_nxt, run_upd;
  logic                 seen_r, seen_nxt, seen_upd;
  logic [POS_WIDTH-1:0] first_r, first_nxt;
  logic [POS_WIDTH-1:0] last_r, last_nxt;
  logic [POS_WIDTH-1:0] pos_upd;

  fss_pkg::fss_len_t    idx_ext;
  fss_pkg::fss_char_t   want_char;
  logic                 hit;
  logic                 adjacent;

  always_comb begin
    active_len = (needle_length > fss_pkg::fss_len_t'(NEEDLE_MAX))
               ? fss_pkg::fss_len_t'(NEEDLE_MAX) : needle_length;
    idx_ext    = fss_pkg::fss_len_t'(idx_r);
    want_char  = needle_chars[idx_ext[2:0]];
    hit        = char_present && (idx_ext < active_len) && (hay_char == want_char);
    adjacent   = seen_r ? (({1'b0, last_r} + 1'b1) == {1'b0, pos_r})
                        : (pos_r == '0);

    idx_upd   = idx_r;
    score_upd = score_r;
    run_upd   = run_r;
    seen_upd  = seen_r;
    first_upd = first_r;
    last_upd  = last_r;
    pos_upd   = pos_r;

    if (hit) begin
      if (adjacent) begin
        run_upd = (run_r < fss_pkg::RUN_MAX) ? run_r + 1'b1 : run_r;
      end else begin
        run_upd = '0;
      end
      first_upd = seen_r ? first_r : pos_r;
      seen_upd  = 1'b1;
      last_upd  = pos_r;
      score_upd = score_r + fss_pkg::HIT_BASE
                + fss_pkg::fss_score_t'(run_upd) * fss_pkg::RUN_STEP
                + ((pos_r == '0) ? fss_pkg::START_BONUS : '0);
      idx_upd   = idx_r + 1'b1;
    end
    if (char_present && (pos_r != POS_LIMIT)) begin
      pos_upd = pos_r + 1'b1;
    end

    flags.empty   = (active_len == '0);
    flags.matched = (fss_pkg::fss_len_t'(idx_upd) >= active_len);

    idx_nxt   = idx_r;
    score_nxt = score_r;
    run_nxt   = run_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    pos_nxt   = pos_r;
    if (go) begin
      if (last_char) begin
        idx_nxt   = '0;
        score_nxt = '0;
        run_nxt   = '0;
        seen_nxt  = 1'b0;
        pos_nxt   = '0;
      end else begin
        idx_nxt   = idx_upd;
        score_nxt = score_upd;
        run_nxt   = run_upd;
        seen_nxt  = seen_upd;
        first_nxt = first_upd;
        last_nxt  = last_upd;
        pos_nxt   = pos_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      score_r <= '0;
      run_r   <= '0;
      seen_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      score_r <= score_nxt;
      run_r   <= run_nxt;
      seen_r  <= seen_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

endmodule

// ===== rtl/fss_score.sv =====
// Final score with penalties and the result register
module fss_score #(
  parameter int POS_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 capture,
  input  logic                 out_stall,
  input  fss_pkg::fss_score_t  score_upd,
  input  logic [POS_WIDTH-1:0] first_upd,
  input  logic [POS_WIDTH-1:0] last_upd,
  input  fss_pkg::fss_len_t    active_len,
  input  fss_pkg::fss_flags_t  flags,
  output logic                 out_valid,
  output fss_pkg::fss_score_t  out_match_score,
  output logic                 out_free
);

  localparam logic [POS_WIDTH-1:0] CAP_POS = POS_WIDTH'(fss_pkg::PENALTY_CAP);

  logic                 valid_r, valid_nxt;
  fss_pkg::fss_score_t  score_r, score_nxt;
  fss_pkg::fss_score_t  final_score;
  fss_pkg::fss_len_t    pen_first, pen_spread;
  logic [4:0]           pen_total;
  logic [POS_WIDTH-1:0] span, len_m1, spread;

  always_comb begin
    pen_first  = (first_upd >= CAP_POS) ? fss_pkg::PENALTY_CAP
                                        : fss_pkg::fss_len_t'(first_upd[3:0]);
    span       = last_upd - first_upd;
    len_m1     = POS_WIDTH'(active_len - 1'b1);
    spread     = (span >= len_m1) ? span - len_m1 : '0;
    pen_spread = (spread >= CAP_POS) ? fss_pkg::PENALTY_CAP
                                     : fss_pkg::fss_len_t'(spread[3:0]);
    pen_total  = 5'(pen_first) + 5'(pen_spread);

    if (flags.empty) begin
      final_score = fss_pkg::EMPTY_SCORE;
    end else if (!flags.matched) begin
      final_score = '0;
    end else if (score_upd > fss_pkg::fss_score_t'(pen_total)) begin
      final_score = score_upd - fss_pkg::fss_score_t'(pen_total);
    end else begin
      final_score = fss_pkg::EMPTY_SCORE;
    end

    out_free  = !valid_r || !out_stall;
    valid_nxt = valid_r && out_stall;
    score_nxt = score_r;
    if (capture) begin
      valid_nxt = 1'b1;
      score_nxt = final_score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
  end

  assign out_valid       = valid_r;
  assign out_match_score = score_r;

endmodule

// ===== rtl/fuzzy_subsequence_scorer_core.sv =====
// Fuzzy subsequence scorer top level: input register, config registers, assertions
// Takes one haystack word per cycle, unless the input side stalls, and scores it against
// the needle held in the configuration registers. A word is held in the input register;
// when it moves on, the match update and, on the last word, the final score are formed
// in one pass and loaded into the match state and the result register. The score is thus
// on the outputs from the result register once its last word has left the input register.
// The input side stalls only while a last word waits for the result register,
// which frees in the same cycle the result is taken.
`include "fuzzy_subsequence_scorer_core_macros.svh"

module fuzzy_subsequence_scorer_core #(
  parameter int NEEDLE_MAX = 8,
  parameter int POS_WIDTH  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fss_pkg::fss_char_t  in_hay_char,
  input  logic                in_char_present,
  input  logic                in_last_char,
  output logic                out_valid,
  input  logic                out_stall,
  output fss_pkg::fss_score_t out_match_score,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  logic                s1_valid_r, s1_valid_nxt;
  fss_pkg::fss_char_t  s1_char_r, s1_char_nxt;
  logic                s1_present_r, s1_present_nxt;
  logic                s1_last_r, s1_last_nxt;
  logic [63:0]         needle_low_r, needle_low_nxt;
  logic [63:0]         needle_high_r, needle_high_nxt;
  fss_pkg::fss_len_t   needle_len_r, needle_len_nxt;

  logic                s1_go;
  logic                in_acc;
  logic                out_free;
  fss_pkg::fss_needle_t needle_chars;
  fss_pkg::fss_score_t score_upd;
  logic [POS_WIDTH-1:0] first_upd, last_upd;
  fss_pkg::fss_len_t   active_len;
  fss_pkg::fss_flags_t flags;

  assign cfg_ready    = 1'b1;
  assign needle_chars = {needle_high_r, needle_low_r};
  assign s1_go        = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall     = s1_valid_r && !s1_go;
  assign in_acc       = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt   = s1_valid_r && !s1_go;
    s1_char_nxt    = s1_char_r;
    s1_present_nxt = s1_present_r;
    s1_last_nxt    = s1_last_r;
    if (in_acc) begin
      s1_valid_nxt   = 1'b1;
      s1_char_nxt    = in_hay_char;
      s1_present_nxt = in_char_present;
      s1_last_nxt    = in_last_char;
    end

    needle_low_nxt  = needle_low_r;
    needle_high_nxt = needle_high_r;
    needle_len_nxt  = needle_len_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fss_pkg::CFG_NEEDLE_LOW:    needle_low_nxt  = cfg_data;
        fss_pkg::CFG_NEEDLE_HIGH:   needle_high_nxt = cfg_data;
        fss_pkg::CFG_NEEDLE_LENGTH: needle_len_nxt  = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      needle_low_r  <= '0;
      needle_high_r <= '0;
      needle_len_r  <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      needle_low_r  <= needle_low_nxt;
      needle_high_r <= needle_high_nxt;
      needle_len_r  <= needle_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_char_r    <= s1_char_nxt;
    s1_present_r <= s1_present_nxt;
    s1_last_r    <= s1_last_nxt;
  end

  fss_match #(
    .NEEDLE_MAX (NEEDLE_MAX),
    .POS_WIDTH  (POS_WIDTH)
  ) u_match (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (s1_go),
    .hay_char      (s1_char_r),
    .char_present  (s1_present_r),
    .last_char     (s1_last_r),
    .needle_chars  (needle_chars),
    .needle_length (needle_len_r),
    .score_upd     (score_upd),
    .first_upd     (first_upd),
    .last_upd      (last_upd),
    .active_len    (active_len),
    .flags         (flags)
  );

  fss_score #(
    .POS_WIDTH (POS_WIDTH)
  ) u_score (
    .clk             (clk),
    .rst_n           (rst_n),
    .capture         (s1_go && s1_last_r),
    .out_stall       (out_stall),
    .score_upd       (score_upd),
    .first_upd       (first_upd),
    .last_upd        (last_upd),
    .active_len      (active_len),
    .flags           (flags),
    .out_valid       (out_valid),
    .out_match_score (out_match_score),
    .out_free        (out_free)
  );

  `FSS_ASSERT_NEXT(a_last_gives_word, s1_go && s1_last_r, out_valid, "last word gave no result")
  `FSS_ASSERT_SAME(a_score_range, out_valid, out_match_score <= fss_pkg::SCORE_MAX, "score out of range")
  `FSS_ASSERT_NEXT(a_empty_needle, s1_go && s1_last_r && flags.empty, out_match_score == fss_pkg::EMPTY_SCORE, "empty needle must score one")
  `FSS_ASSERT_NEXT(a_unmatched_zero, s1_go && s1_last_r && !flags.empty && !flags.matched, out_match_score == '0, "unmatched needle must score zero")

endmodule

// ===== verif/fuzzy_subsequence_scorer_core_tb.sv =====
// Testbench for the fuzzy subsequence scorer core: directed and random haystacks scored by a predictor
module fuzzy_subsequence_scorer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = 4;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 550;
  localparam int HOLD_CYCLES  = 160;
  localparam int POS_LIMIT    = 65535;
  localparam int CAP          = int'(fss_pkg::PENALTY_CAP);
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam fss_pkg::fss_char_t FILL_CHAR = 16'h007a;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;

  typedef struct {
    fss_pkg::fss_char_t ch;
    logic               present;
  } hay_word_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fss_pkg::fss_char_t  in_hay_char;
  logic                in_char_present;
  logic                in_last_char;
  logic                out_valid;
  logic                out_stall;
  fss_pkg::fss_score_t out_match_score;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [63:0]         cfg_data;

  fss_pkg::fss_score_t score_q[$];
  fss_pkg::fss_score_t want;
  int errors = 0;
  int words_sent = 0;
  int scores_seen = 0;
  int nonzero_scores = 0;
  int cycle_count = 0;

  bit       pace_on = 1'b0;
  int       burst_left = 0;
  int       gap_len;
  rx_mode_t stall_mode = RX_FREE;
  bit       long_hold = 1'b0;
  int       hold_left = 0;
  int       stall_phase = 0;
  logic     stall_nxt;

  fss_pkg::fss_needle_t needle;
  fss_pkg::fss_len_t    needle_len;
  int match_idx, hay_pos, run_score, run_len, first_hit, prev_hit;

  fuzzy_subsequence_scorer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_hay_char     (in_hay_char),
    .in_char_present (in_char_present),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_score (out_match_score),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d scores outstanding", cycle_count,
               score_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold
  always @(negedge clk) begin
    if (long_hold) begin
      hold_left = HOLD_CYCLES;
      long_hold = 1'b0;
    end
    stall_phase = (stall_phase + 1) % 11;
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else begin
      case (stall_mode)
        RX_FREE:    stall_nxt = 1'b0;
        RX_RANDOM:  stall_nxt = ($urandom_range(0, 3) == 0);
        RX_PATTERN: stall_nxt = (stall_phase < 4);
        default:    stall_nxt = ($urandom_range(0, 9) < 7);
      endcase
    end
    out_stall <= stall_nxt;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      scores_seen++;
      if (out_match_score != 0) nonzero_scores++;
      if (score_q.size() == 0) begin
        errors++;
        $display("%0t: score with nothing expected: expected none, actual %0d", $time,
                 out_match_score);
      end else begin
        want = score_q.pop_front();
        if (out_match_score !== want) begin
          errors++;
          $display("%0t: match_score mismatch: expected %0d, actual %0d", $time, want,
                   out_match_score);
        end
      end
    end
  end

  function automatic int active_len();
    return (int'(needle_len) > fss_pkg::SLOTS) ? fss_pkg::SLOTS : int'(needle_len);
  endfunction

  task automatic clear_tracking();
    match_idx = 0;
    hay_pos   = 0;
    run_score = 0;
    run_len   = 0;
    first_hit = -1;
    prev_hit  = -1;
  endtask

  function automatic fss_pkg::fss_score_t closing_score();
    int n, s, spread;
    n = active_len();
    if (n == 0) return fss_pkg::EMPTY_SCORE;
    if (match_idx < n) return '0;
    s = run_score;
    if (first_hit > 0) s -= (first_hit < CAP) ? first_hit : CAP;
    spread = (prev_hit - first_hit) - (n - 1);
    if (spread < 0) spread = 0;
    s -= (spread < CAP) ? spread : CAP;
    if (s < 1) s = 1;
    return fss_pkg::fss_score_t'(s);
  endfunction

  task automatic track_word(input fss_pkg::fss_char_t ch, input logic present,
                            input logic last);
    if (present) begin
      if (match_idx < active_len() && ch == needle[match_idx]) begin
        if (first_hit < 0) first_hit = hay_pos;
        if (prev_hit == hay_pos - 1) begin
          if (run_len < int'(fss_pkg::RUN_MAX)) run_len++;
        end else begin
          run_len = 0;
        end
        prev_hit = hay_pos;
        run_score = run_score + int'(fss_pkg::HIT_BASE) + int'(fss_pkg::RUN_STEP) * run_len;
        if (hay_pos == 0) run_score = run_score + int'(fss_pkg::START_BONUS);
        run_score = run_score & 'h1FF;
        match_idx++;
      end
      if (hay_pos < POS_LIMIT) hay_pos++;
    end
    if (last) begin
      score_q.push_back(closing_score());
      clear_tracking();
    end
  endtask

  task automatic send_word(input fss_pkg::fss_char_t ch, input logic present,
                           input logic last);
    @(negedge clk);
    if (pace_on) begin
      if (burst_left == 0) begin
        gap_len = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid        <= 1'b1;
    in_hay_char     <= ch;
    in_char_present <= present;
    in_last_char    <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    track_word(ch, present, last);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int k = 0; k < s.len(); k++)
      send_word(fss_pkg::fss_char_t'(s[k]), 1'b1, close && (k == s.len() - 1));
  endtask

  // drop valid, drain every expected score, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fss_pkg::CFG_NEEDLE_LOW:    needle[3:0] = data;
      fss_pkg::CFG_NEEDLE_HIGH:   needle[7:4] = data;
      fss_pkg::CFG_NEEDLE_LENGTH: needle_len = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_needle(input fss_pkg::fss_needle_t nd, input logic [63:0] len_word);
    write_reg(fss_pkg::CFG_NEEDLE_LOW, nd[3:0]);
    write_reg(fss_pkg::CFG_NEEDLE_HIGH, nd[7:4]);
    write_reg(fss_pkg::CFG_NEEDLE_LENGTH, len_word);
  endtask

  function automatic fss_pkg::fss_needle_t needle_of(input string s);
    fss_pkg::fss_needle_t nd;
    nd = '0;
    for (int k = 0; k < s.len(); k++) nd[k] = fss_pkg::fss_char_t'(s[k]);
    return nd;
  endfunction

  function automatic fss_pkg::fss_char_t random_letter();
    return fss_pkg::fss_char_t'(16'h0061 + $urandom_range(0, 5));
  endfunction

  function automatic hay_word_t filler();
    hay_word_t w;
    w.present = ($urandom_range(0, 9) != 0);
    w.ch = ($urandom_range(0, 4) == 0 || !w.present) ? fss_pkg::fss_char_t'($urandom)
                                                      : random_letter();
    return w;
  endfunction

  task automatic test_empty_needle();
    settle();
    pace_on = 1'b1;
    stall_mode = RX_RANDOM;
    send_text("ab", 1'b1);
    send_word(16'h0000, 1'b0, 1'b1);
  endtask

  task automatic test_full_needle();
    settle();
    load_needle(needle_of("abcdefgh"), '1);
    send_text("abcdefgh", 1'b1);
  endtask

  task automatic test_penalties();
    settle();
    load_needle(needle_of("abc"), 64'd3);
    send_text("za", 1'b0);
    send_word(16'h0062, 1'b0, 1'b0);
    send_text("xbc", 1'b1);
    send_text("ca", 1'b1);
  endtask

  task automatic test_char_extremes();
    fss_pkg::fss_needle_t nd;
    settle();
    nd = '0;
    nd[0] = 16'hFFFF;
    load_needle(nd, 64'd2);
    write_reg(CFG_SPARE, '1);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b1, 1'b1);
  endtask

  task automatic test_mid_haystack_write();
    settle();
    load_needle(needle_of("abc"), 64'd3);
    send_text("ab", 1'b0);
    settle();
    write_reg(fss_pkg::CFG_NEEDLE_LENGTH, 64'd2);
    send_text("q", 1'b1);
  endtask

  task automatic test_long_haystack();
    settle();
    load_needle(needle_of("abc"), 64'd3);
    pace_on = 1'b0;
    stall_mode = RX_FREE;
    repeat (30) send_word(FILL_CHAR, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_text("abc", 1'b1);
    send_text("a", 1'b0);
    repeat (25) send_word(FILL_CHAR, 1'b1, 1'b0);
    send_text("bc", 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    settle();
    load_needle(needle_of("ab"), 64'd2);
    pace_on = 1'b0;
    stall_mode = RX_FREE;
    @(posedge clk);
    long_hold = 1'b1;
    for (int k = 0; k < 12; k++) send_word(k[0] ? 16'h0061 : 16'h0062, 1'b1, 1'b1);
    settle();
  endtask

  task automatic test_random();
    hay_word_t            hay[$];
    fss_pkg::fss_needle_t nd;
    int n, len, sent, phase;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      case (phase % 5)
        0:       len = $urandom_range(1, 8);
        1:       len = 0;
        2:       len = fss_pkg::SLOTS;
        3:       len = $urandom_range(9, 15);
        default: len = $urandom_range(0, 15);
      endcase
      for (int k = 0; k < fss_pkg::SLOTS; k++)
        nd[k] = (phase % 5 == 4) ? fss_pkg::fss_char_t'($urandom) : random_letter();
      load_needle(nd, {32'($urandom), 28'($urandom), 4'(len)});
      n = (len > fss_pkg::SLOTS) ? fss_pkg::SLOTS : len;
      pace_on = ($urandom_range(0, 3) != 0);
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      repeat (6) begin
        hay.delete();
        if ($urandom_range(0, 9) < 7) begin
          for (int k = 0; k < n; k++) begin
            repeat ($urandom_range(0, 3)) hay.push_back(filler());
            if ($urandom_range(0, 19) != 0) hay.push_back('{nd[k], 1'b1});
          end
          repeat ($urandom_range(0, 3)) hay.push_back(filler());
        end else begin
          repeat ($urandom_range(0, 12)) hay.push_back(filler());
        end
        if (hay.size() == 0 || $urandom_range(0, 3) == 0)
          hay.push_back('{fss_pkg::fss_char_t'($urandom), 1'b0});
        foreach (hay[k]) send_word(hay[k].ch, hay[k].present, k == hay.size() - 1);
        sent += hay.size();
      end
      phase++;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_hay_char     = '0;
    in_char_present = 1'b0;
    in_last_char    = 1'b0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = fss_pkg::CFG_NEEDLE_LOW;
    cfg_data        = '0;
    needle          = '0;
    needle_len      = '0;
    clear_tracking();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_needle();
    test_full_needle();
    test_penalties();
    test_char_extremes();
    test_mid_haystack_write();
    test_long_haystack();
    test_backpressure();
    test_random();
    settle();

    $display("Checked %0d scores (%0d non-zero) from %0d words sent", scores_seen,
             nonzero_scores, words_sent);
    $display("Covered empty, oversized and random needles, capped penalties and long holds");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
